[design/dtes_pkg.sv]
`timescale 1ns / 1ps

package dtes_pkg;

    // Field widths
    localparam int C_YEAR_W   = 12;
    localparam int C_MONTH_W  = 4;
    localparam int C_DAY_W    = 5;
    localparam int C_HOUR_W   = 5;
    localparam int C_MIN_W    = 6;
    localparam int C_SEC_W    = 6;
    localparam int C_MAXY_W   = 11;
    localparam int C_EPOCH_W  = 32;

    localparam int C_BASE_YEAR = 1970;
    localparam logic [C_MAXY_W-1:0] C_MAXY_RESET = 11'd2034;

    // floor(n / 100) = (n * 1311) >> 17, exact for any 12-bit n
    localparam int C_DIV100_MUL_W = 11;
    localparam logic [C_DIV100_MUL_W-1:0] C_DIV100_MUL = 11'd1311;
    localparam int C_DIV100_SHIFT = 17;
    localparam int C_PROD_W       = C_YEAR_W + C_DIV100_MUL_W;
    localparam int C_Q_W          = C_PROD_W - C_DIV100_SHIFT;
    localparam int C_LEAPS_W      = 10;
    localparam int C_YEARS_W      = 9;
    localparam int C_YDAYS_W      = 18;
    localparam int C_CUM_W        = 9;

    localparam int C_MONTHS   = 12;
    localparam int C_MIDX_W   = 4;
    localparam int C_HOUR_MAX = 23;
    localparam int C_MIN_MAX  = 59;
    localparam int C_SEC_MAX  = 59;
    localparam int C_FEB_IDX  = 1;

    localparam logic [C_EPOCH_W-1:0] C_DAYS_PER_YEAR = 32'd365;
    localparam logic [C_EPOCH_W-1:0] C_HOURS_PER_DAY = 32'd24;
    localparam logic [C_EPOCH_W-1:0] C_SECS_PER_HOUR = 32'd3600;
    localparam logic [C_EPOCH_W-1:0] C_SECS_PER_MIN  = 32'd60;

    localparam int C_STAGES = 6;

    localparam logic [C_CUM_W-1:0] C_CUM_DAYS [C_MONTHS] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    localparam logic [C_DAY_W-1:0] C_MONTH_LEN [C_MONTHS] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic                 leap;
        logic [C_Q_W-1:0]     q100;
        logic [C_LEAPS_W-1:0] leaps;
    } t_leap_info;

    // Leap days in years 1..n; elaboration use only
    function automatic int leaps_upto(int n);
        return n / 4 - n / 100 + n / 400;
    endfunction

endpackage

[design/dtes_ifs.sv]
`timescale 1ns / 1ps

interface dtes_date_if;
    import dtes_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [C_YEAR_W-1:0]  year;
    logic [C_MONTH_W-1:0] month;
    logic [C_DAY_W-1:0]   day;
    logic [C_HOUR_W-1:0]  hour;
    logic [C_MIN_W-1:0]   minute;
    logic [C_SEC_W-1:0]   second;
    modport source (output valid, year, month, day, hour, minute, second, input ready);
    modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

interface dtes_epoch_if;
    import dtes_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [C_EPOCH_W-1:0] epoch_seconds;
    logic                 valid_res;
    modport source (output valid, epoch_seconds, valid_res, input ready);
    modport sink   (input valid, epoch_seconds, valid_res, output ready);
endinterface

interface dtes_cfg_if;
    import dtes_pkg::*;
    logic                valid;
    logic                ready;
    logic [C_MAXY_W-1:0] max_year;
    modport source (output valid, max_year, input ready);
    modport sink   (input valid, max_year, output ready);
endinterface

[design/dtes_leap.sv]
`timescale 1ns / 1ps

module dtes_leap (
    input  logic [dtes_pkg::C_YEAR_W-1:0] i_n,
    input  logic [dtes_pkg::C_PROD_W-1:0] i_prod,
    output dtes_pkg::t_leap_info          o_info
);
    import dtes_pkg::*;

    logic [C_Q_W-1:0]    w_q;
    logic [C_YEAR_W-1:0] w_rem;

    // i_prod holds i_n times the reciprocal of 100
    assign w_q   = i_prod[C_PROD_W-1 -: C_Q_W];
    assign w_rem = i_n - C_YEAR_W'(w_q) * C_YEAR_W'(100);

    // Gregorian: div by 4, not by 100 unless by 400
    assign o_info.leap  = (i_n[1:0] == 2'b00) && ((w_rem != '0) || (w_q[1:0] == 2'b00));
    assign o_info.q100  = w_q;
    assign o_info.leaps = C_LEAPS_W'(i_n >> 2) - C_LEAPS_W'(w_q) + C_LEAPS_W'(w_q >> 2);

endmodule

[design/datetime_to_epoch_seconds.sv]
`timescale 1ns / 1ps

// Calendar date/time to seconds since BASE_YEAR-01-01 00:00:00 UTC.
//
// i_date: one beat carries year, month, day, hour, minute, second.
// o_epoch: one beat per input beat, in order, with epoch_seconds (mod 2^32)
//   and valid_res, set when every field is inside its calendar range.
// i_cfg: writes max_year; always ready. Write it only while the block is idle.
//
// Six register stages: clamp and range check, divide-by-100 products,
// leap logic and whole-year days, day count, hours, seconds. A beat
// moves through the stage registers in order and shows on o_epoch
// from the seconds stage, the output register; one beat per cycle is
// sustained while o_epoch.ready stays high.
// Each stage holds a valid bit; ready ripples back from o_epoch, so an
// empty stage keeps taking beats while the output stalls, and a full
// stalled pipe drops i_date.ready without losing or repeating a beat.
// Reset (i_rst_n low at a clock edge) empties the pipe and sets max_year
// to 2034.
module datetime_to_epoch_seconds #(
    parameter int BASE_YEAR = dtes_pkg::C_BASE_YEAR
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dtes_date_if.sink         i_date,
    dtes_epoch_if.source      o_epoch,
    dtes_cfg_if.sink          i_cfg
);
    import dtes_pkg::*;

    localparam logic [C_YEAR_W-1:0]  L_BASE       = C_YEAR_W'(BASE_YEAR);
    localparam logic [C_LEAPS_W-1:0] L_BASE_LEAPS = C_LEAPS_W'(leaps_upto(BASE_YEAR - 1));

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [C_MAXY_W-1:0] r_max_year;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_year <= C_MAXY_RESET;
        end else if (i_cfg.valid) begin
            r_max_year <= i_cfg.max_year;
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control: valid per stage, ready ripples back
    // ---------------------------------------------------------------
    logic [C_STAGES:1] r_v;
    logic [C_STAGES:1] w_ce;
    logic [C_STAGES:1] n_v;

    always_comb begin
        w_ce[C_STAGES] = !r_v[C_STAGES] || o_epoch.ready;
        for (int k = C_STAGES - 1; k >= 1; k--) begin
            w_ce[k] = !r_v[k] || w_ce[k+1];
        end
        n_v[1] = i_date.valid;
        for (int k = 2; k <= C_STAGES; k++) begin
            n_v[k] = r_v[k-1];
        end
    end

    assign i_date.ready = w_ce[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k <= C_STAGES; k++) begin
                if (w_ce[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: clamp year and month, range checks that need no table
    // ---------------------------------------------------------------
    logic [C_MAXY_W-1:0]  w_top;
    logic [C_YEAR_W-1:0]  w_top_floor;
    logic                 w_month_ok;
    logic [C_YEAR_W-1:0]  n1_y;
    logic [C_MIDX_W-1:0]  n1_mi;
    logic [C_MIDX_W-1:0]  n1_len_idx;
    logic                 n1_ok;

    logic [C_YEAR_W-1:0]  r1_y;
    logic [C_YEAR_W-1:0]  r1_year;
    logic [C_MIDX_W-1:0]  r1_mi;
    logic [C_MIDX_W-1:0]  r1_len_idx;
    logic [C_DAY_W-1:0]   r1_day;
    logic [C_HOUR_W-1:0]  r1_hour;
    logic [C_MIN_W-1:0]   r1_minute;
    logic [C_SEC_W-1:0]   r1_second;
    logic                 r1_ok;

    always_comb begin
        w_top       = (r_max_year != '0) ? r_max_year - C_MAXY_W'(1) : '0;
        // a top below the base year falls back to the base year
        w_top_floor = ({1'b0, w_top} < L_BASE) ? L_BASE : {1'b0, w_top};
        if (i_date.year < L_BASE) begin
            n1_y = L_BASE;
        end else if (i_date.year > {1'b0, w_top}) begin
            n1_y = w_top_floor;
        end else begin
            n1_y = i_date.year;
        end

        w_month_ok = (i_date.month >= C_MONTH_W'(1)) && (i_date.month <= C_MONTH_W'(C_MONTHS));
        // month 0 converts as January, 13..15 as December
        if (i_date.month == '0) begin
            n1_mi = '0;
        end else if (i_date.month > C_MONTH_W'(C_MONTHS)) begin
            n1_mi = C_MIDX_W'(C_MONTHS - 1);
        end else begin
            n1_mi = C_MIDX_W'(i_date.month - C_MONTH_W'(1));
        end
        n1_len_idx = w_month_ok ? C_MIDX_W'(i_date.month - C_MONTH_W'(1)) : '0;

        n1_ok = (i_date.year >= L_BASE) && (i_date.year <= {1'b0, r_max_year})
              && w_month_ok && (i_date.day != '0)
              && (i_date.hour <= C_HOUR_W'(C_HOUR_MAX))
              && (i_date.minute <= C_MIN_W'(C_MIN_MAX))
              && (i_date.second <= C_SEC_W'(C_SEC_MAX));
    end

    always_ff @(posedge i_clk) begin
        if (w_ce[1]) begin
            r1_y       <= n1_y;
            r1_year    <= i_date.year;
            r1_mi      <= n1_mi;
            r1_len_idx <= n1_len_idx;
            r1_day     <= i_date.day;
            r1_hour    <= i_date.hour;
            r1_minute  <= i_date.minute;
            r1_second  <= i_date.second;
            r1_ok      <= n1_ok;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: reciprocal products for divide by 100
    // ---------------------------------------------------------------
    logic [C_PROD_W-1:0]  r2_prod_y;
    logic [C_PROD_W-1:0]  r2_prod_year;
    logic [C_YEAR_W-1:0]  r2_y;
    logic [C_YEAR_W-1:0]  r2_year;
    logic [C_MIDX_W-1:0]  r2_mi;
    logic [C_MIDX_W-1:0]  r2_len_idx;
    logic [C_DAY_W-1:0]   r2_day;
    logic [C_HOUR_W-1:0]  r2_hour;
    logic [C_MIN_W-1:0]   r2_minute;
    logic [C_SEC_W-1:0]   r2_second;
    logic                 r2_ok;

    always_ff @(posedge i_clk) begin
        if (w_ce[2]) begin
            r2_prod_y    <= C_PROD_W'(r1_y) * C_PROD_W'(C_DIV100_MUL);
            r2_prod_year <= C_PROD_W'(r1_year) * C_PROD_W'(C_DIV100_MUL);
            r2_y         <= r1_y;
            r2_year      <= r1_year;
            r2_mi        <= r1_mi;
            r2_len_idx   <= r1_len_idx;
            r2_day       <= r1_day;
            r2_hour      <= r1_hour;
            r2_minute    <= r1_minute;
            r2_second    <= r1_second;
            r2_ok        <= r1_ok;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: leap years, days of whole years, day-of-month check
    // ---------------------------------------------------------------
    t_leap_info           w_y_info;
    t_leap_info           w_year_info;
    logic [C_YEARS_W-1:0] w_years;
    logic [C_DAY_W-1:0]   w_mlen;
    logic [C_YDAYS_W-1:0] n3_ydays;
    logic                 n3_ok;

    logic [C_YDAYS_W-1:0] r3_ydays;
    logic                 r3_leap_y;
    logic [C_MIDX_W-1:0]  r3_mi;
    logic [C_DAY_W-1:0]   r3_day;
    logic [C_HOUR_W-1:0]  r3_hour;
    logic [C_MIN_W-1:0]   r3_minute;
    logic [C_SEC_W-1:0]   r3_second;
    logic                 r3_ok;

    dtes_leap u_leap_clamped (
        .i_n    (r2_y),
        .i_prod (r2_prod_y),
        .o_info (w_y_info)
    );

    dtes_leap u_leap_raw (
        .i_n    (r2_year),
        .i_prod (r2_prod_year),
        .o_info (w_year_info)
    );

    always_comb begin
        w_years  = C_YEARS_W'(r2_y - L_BASE);
        // leap days in years base..y-1 = L(y) - leap(y) - L(base-1)
        n3_ydays = C_YDAYS_W'(w_years) * C_YDAYS_W'(C_DAYS_PER_YEAR)
                 + C_YDAYS_W'(w_y_info.leaps - C_LEAPS_W'(w_y_info.leap) - L_BASE_LEAPS);
        w_mlen   = C_MONTH_LEN[r2_len_idx]
                 + C_DAY_W'((r2_len_idx == C_MIDX_W'(C_FEB_IDX)) && w_year_info.leap);
        n3_ok    = r2_ok && (r2_day <= w_mlen);
    end

    always_ff @(posedge i_clk) begin
        if (w_ce[3]) begin
            r3_ydays  <= n3_ydays;
            r3_leap_y <= w_y_info.leap;
            r3_mi     <= r2_mi;
            r3_day    <= r2_day;
            r3_hour   <= r2_hour;
            r3_minute <= r2_minute;
            r3_second <= r2_second;
            r3_ok     <= n3_ok;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: day count; day 0 wraps below zero on purpose
    // ---------------------------------------------------------------
    logic [C_EPOCH_W-1:0] n4_days;
    logic [C_EPOCH_W-1:0] r4_days;
    logic [C_HOUR_W-1:0]  r4_hour;
    logic [C_MIN_W-1:0]   r4_minute;
    logic [C_SEC_W-1:0]   r4_second;
    logic                 r4_ok;

    assign n4_days = C_EPOCH_W'(r3_ydays) + C_EPOCH_W'(C_CUM_DAYS[r3_mi])
                   + C_EPOCH_W'((r3_mi > C_MIDX_W'(C_FEB_IDX)) && r3_leap_y)
                   + C_EPOCH_W'(r3_day) - C_EPOCH_W'(1);

    always_ff @(posedge i_clk) begin
        if (w_ce[4]) begin
            r4_days   <= n4_days;
            r4_hour   <= r3_hour;
            r4_minute <= r3_minute;
            r4_second <= r3_second;
            r4_ok     <= r3_ok;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: hours
    // ---------------------------------------------------------------
    logic [C_EPOCH_W-1:0] r5_hours;
    logic [C_MIN_W-1:0]   r5_minute;
    logic [C_SEC_W-1:0]   r5_second;
    logic                 r5_ok;

    always_ff @(posedge i_clk) begin
        if (w_ce[5]) begin
            r5_hours  <= r4_days * C_HOURS_PER_DAY + C_EPOCH_W'(r4_hour);
            r5_minute <= r4_minute;
            r5_second <= r4_second;
            r5_ok     <= r4_ok;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: seconds, output register
    // ---------------------------------------------------------------
    logic [C_EPOCH_W-1:0] r6_secs;
    logic                 r6_ok;

    always_ff @(posedge i_clk) begin
        if (w_ce[6]) begin
            r6_secs <= r5_hours * C_SECS_PER_HOUR
                     + C_EPOCH_W'(r5_minute) * C_SECS_PER_MIN
                     + C_EPOCH_W'(r5_second);
            r6_ok   <= r5_ok;
        end
    end

    assign o_epoch.valid         = r_v[C_STAGES];
    assign o_epoch.epoch_seconds = r6_secs;
    assign o_epoch.valid_res     = r6_ok;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_full_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_v) && !o_epoch.ready) |-> !i_date.ready)
        else $error("input ready while pipe full and output stalled");

    a_bubble_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(&r_v) |-> i_date.ready)
        else $error("input not ready although a stage is empty");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_date.valid && i_date.ready) |=> r_v[1])
        else $error("accepted beat did not enter stage 1");

endmodule

[tb/datetime_to_epoch_seconds_tb.sv]
`timescale 1ns / 1ps

module datetime_to_epoch_seconds_tb;
    import dtes_pkg::*;

    localparam logic [31:0] EPOCH_BASE = 32'(C_BASE_YEAR);

    typedef struct packed {
        logic [C_YEAR_W-1:0]  year;
        logic [C_MONTH_W-1:0] month;
        logic [C_DAY_W-1:0]   day;
        logic [C_HOUR_W-1:0]  hour;
        logic [C_MIN_W-1:0]   minute;
        logic [C_SEC_W-1:0]   second;
    } t_date;

    typedef struct packed {
        logic [C_EPOCH_W-1:0] secs;
        logic                 ok;
    } t_epoch;

    // Keep the conversion state (only max_year) and the queue of results (seconds
    // and valid_res) still owed by the block, oldest first.
    class epoch_scoreboard;
        logic [C_MAXY_W-1:0] max_year;
        t_epoch              expected_epochs[$];
        int                  mismatches;
        int                  dates_checked;
        int                  in_range_dates;

        function new();
            max_year        = C_MAXY_RESET;
            mismatches      = 0;
            dates_checked   = 0;
            in_range_dates  = 0;
        endfunction

        // Days in the months before month index m (0 = January, 12 = whole year).
        static function logic [31:0] days_before(int unsigned m);
            case (m)
                0:       return 32'd0;
                1:       return 32'd31;
                2:       return 32'd59;
                3:       return 32'd90;
                4:       return 32'd120;
                5:       return 32'd151;
                6:       return 32'd181;
                7:       return 32'd212;
                8:       return 32'd243;
                9:       return 32'd273;
                10:      return 32'd304;
                11:      return 32'd334;
                default: return 32'd365;
            endcase
        endfunction

        static function bit is_leap(logic [31:0] y);
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        // Leap days in years 1 through n.
        static function logic [31:0] leap_days(logic [31:0] n);
            return n / 4 - n / 100 + n / 400;
        endfunction

        function t_epoch compute_epoch(t_date d);
            logic [31:0] yr;
            logic [31:0] top;
            logic [31:0] y;
            logic [31:0] mi;
            logic [31:0] days;
            logic [31:0] mchk;
            logic [31:0] mlen;
            t_epoch      res;
            yr  = 32'(d.year);
            top = (max_year >= 1) ? 32'(max_year) - 32'd1 : 32'd0;
            // Clamp to the base year, then to max_year - 1, then back up to the
            // base year when max_year - 1 falls below it.
            y = yr;
            if (y < EPOCH_BASE) y = EPOCH_BASE;
            if (y > top) y = top;
            if (y < EPOCH_BASE) y = EPOCH_BASE;
            // Month zero converts as January, 13..15 as December.
            mi = (d.month == 0) ? 32'd0 : 32'(d.month) - 32'd1;
            if (mi > C_MONTHS - 1) mi = C_MONTHS - 1;
            days = (y - EPOCH_BASE) * 32'd365
                 + (leap_days(y - 32'd1) - leap_days(EPOCH_BASE - 32'd1));
            days = days + days_before(mi);
            if (mi > C_FEB_IDX && is_leap(y)) days = days + 32'd1;
            // Day zero subtracts a day; everything wraps modulo 2^32.
            days = days + 32'(d.day) - 32'd1;
            res.secs = (days * 32'd24 + 32'(d.hour)) * 32'd3600
                     + 32'(d.minute) * 32'd60 + 32'(d.second);
            // Range check works on the unclamped year and month.
            mchk = (d.month >= 1 && d.month <= C_MONTHS) ? 32'(d.month) : 32'd1;
            mlen = days_before(mchk) - days_before(mchk - 32'd1)
                 + ((mchk == C_FEB_IDX + 1 && is_leap(yr)) ? 32'd1 : 32'd0);
            res.ok = yr >= EPOCH_BASE && yr <= 32'(max_year)
                  && d.month >= 1 && d.month <= C_MONTHS
                  && d.day >= 1 && 32'(d.day) <= mlen
                  && d.hour <= C_HOUR_MAX && d.minute <= C_MIN_MAX
                  && d.second <= C_SEC_MAX;
            return res;
        endfunction

        function void note_date(t_date d);
            expected_epochs.push_back(compute_epoch(d));
        endfunction

        function int pending();
            return expected_epochs.size();
        endfunction

        task report(string msg);
            mismatches++;
            $display("ERROR @%0t: %s", $realtime, msg);
        endtask

        task check_epoch(logic [C_EPOCH_W-1:0] secs, logic ok);
            t_epoch want;
            if (expected_epochs.size() == 0) begin
                report($sformatf("unexpected result beat secs=%0d ok=%0b", secs, ok));
                return;
            end
            want = expected_epochs.pop_front();
            dates_checked++;
            if (want.ok) in_range_dates++;
            if (secs !== want.secs)
                report($sformatf("epoch_seconds got %0d want %0d", secs, want.secs));
            if (ok !== want.ok)
                report($sformatf("valid_res got %0b want %0b", ok, want.ok));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    dtes_date_if  date_bus();
    dtes_epoch_if epoch_bus();
    dtes_cfg_if   cfg_bus();

    epoch_scoreboard sb = new();

    // Percent chance of a gap before a date beat and of a stall on the result
    // side; zeroed for the back-to-back stretch.
    int idle_pct = 15;
    int dates_sent = 0;
    int settings_used = 1;

    datetime_to_epoch_seconds i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_date  (date_bus),
        .o_epoch (epoch_bus),
        .i_cfg   (cfg_bus)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_date date_of(int y, int mo, int d, int h, int mi, int s);
        t_date r;
        r.year   = C_YEAR_W'(y);
        r.month  = C_MONTH_W'(mo);
        r.day    = C_DAY_W'(d);
        r.hour   = C_HOUR_W'(h);
        r.minute = C_MIN_W'(mi);
        r.second = C_SEC_W'(s);
        return r;
    endfunction

    // Well-formed dates up to max_year (base year + 40 if max_year <= base year),
    // plus late days of the month, years at the limit, one broken field, raw noise.
    function automatic t_date random_date(logic [C_MAXY_W-1:0] maxy);
        t_date       d;
        int unsigned pick;
        int unsigned hi;
        pick = $urandom_range(99);
        hi = (maxy > C_BASE_YEAR) ? 32'(maxy) : C_BASE_YEAR + 40;
        d = date_of($urandom_range(hi, C_BASE_YEAR), $urandom_range(C_MONTHS, 1),
                    $urandom_range(28, 1), $urandom_range(C_HOUR_MAX),
                    $urandom_range(C_MIN_MAX), $urandom_range(C_SEC_MAX));
        if (pick < 20) begin
            d.day = C_DAY_W'($urandom_range(31, 29));
        end else if (pick < 30) begin
            d.year = C_YEAR_W'(maxy) + C_YEAR_W'($urandom_range(1));
        end else if (pick < 40) begin
            case ($urandom_range(3))
                0:       d.month  = C_MONTH_W'($urandom_range(1) ? $urandom_range(15, 13) : 0);
                1:       d.hour   = C_HOUR_W'($urandom_range(31, 24));
                2:       d.minute = C_MIN_W'($urandom_range(63, 60));
                default: d.second = C_SEC_W'($urandom_range(63, 60));
            endcase
        end else if (pick < 70) begin
            d = date_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        return d;
    endfunction

    // Present one date beat, optionally after a one-cycle gap, and hold it
    // until taken.
    task automatic send_date(t_date d);
        if ($urandom_range(99) < idle_pct) begin
            date_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        date_bus.valid  <= 1'b1;
        date_bus.year   <= d.year;
        date_bus.month  <= d.month;
        date_bus.day    <= d.day;
        date_bus.hour   <= d.hour;
        date_bus.minute <= d.minute;
        date_bus.second <= d.second;
        do @(posedge i_clk); while (!date_bus.ready);
        sb.note_date(d);
        dates_sent++;
    endtask

    // Drop valid and hold until every owed result has come back.
    task automatic wait_for_epochs();
        date_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_max_year(logic [C_MAXY_W-1:0] v);
        cfg_bus.valid    <= 1'b1;
        cfg_bus.max_year <= v;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        sb.max_year = v;
        settings_used++;
    endtask

    // One max_year setting: write it, hit the year limit, then random dates.
    task automatic run_phase(logic [C_MAXY_W-1:0] maxy, int n);
        write_max_year(maxy);
        send_date(date_of(32'(maxy) - 1, 12, 31, 23, 59, 59));
        send_date(date_of(int'(maxy), 2, 29, 0, 0, 0));
        send_date(date_of(int'(maxy), 12, 31, 23, 59, 59));
        send_date(date_of(32'(maxy) + 1, 1, 1, 0, 0, 0));
        repeat (n) send_date(random_date(maxy));
        wait_for_epochs();
    endtask

    // Result side: check every accepted beat, stall at random.
    initial begin
        epoch_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && epoch_bus.valid && epoch_bus.ready)
                sb.check_epoch(epoch_bus.epoch_seconds, epoch_bus.valid_res);
            epoch_bus.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results outstanding", sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_rst_n          <= 1'b0;
        date_bus.valid   <= 1'b0;
        date_bus.year    <= '0;
        date_bus.month   <= '0;
        date_bus.day     <= '0;
        date_bus.hour    <= '0;
        date_bus.minute  <= '0;
        date_bus.second  <= '0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.max_year <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed dates with the reset limit of 2034 in place.
        send_date(date_of(1970, 1, 1, 0, 0, 0));
        send_date(date_of(2033, 12, 31, 23, 59, 59));
        send_date(date_of(2034, 12, 31, 23, 59, 59)); // at the limit: in range, clamped
        send_date(date_of(2035, 6, 15, 12, 30, 30));  // past the limit
        send_date(date_of(1969, 12, 31, 23, 59, 59)); // before the base year
        send_date(date_of(0, 0, 0, 0, 0, 0));
        send_date(date_of(4095, 15, 31, 31, 63, 63));
        send_date(date_of(2024, 2, 29, 12, 0, 0));
        send_date(date_of(2023, 2, 29, 12, 0, 0));    // not a leap year
        send_date(date_of(2000, 2, 29, 0, 0, 1));     // leap by the 400 rule
        send_date(date_of(2000, 3, 1, 0, 0, 0));
        send_date(date_of(2100, 2, 29, 0, 0, 0));     // century, not leap
        send_date(date_of(2024, 4, 31, 0, 0, 0));
        send_date(date_of(2024, 0, 10, 8, 0, 0));     // month zero reads as January
        send_date(date_of(2024, 13, 10, 8, 0, 0));    // above twelve reads as December
        send_date(date_of(2024, 15, 10, 8, 0, 0));
        send_date(date_of(1970, 1, 0, 0, 0, 0));      // day zero wraps below zero
        send_date(date_of(2030, 7, 4, 24, 0, 0));
        send_date(date_of(2030, 7, 4, 31, 60, 60));
        send_date(date_of(2030, 7, 4, 0, 63, 0));
        send_date(date_of(2030, 7, 4, 0, 0, 63));
        send_date(date_of(2024, 12, 31, 23, 59, 59));
        repeat (180) send_date(random_date(C_MAXY_RESET));
        wait_for_epochs();

        run_phase(11'd1971, 120);
        idle_pct = 0;                // long back-to-back stretch on both sides
        run_phase(11'd2047, 200);
        idle_pct = 15;
        run_phase(11'd0, 100);       // limit below the base year
        run_phase(11'd1970, 100);
        run_phase(11'd2000, 120);
        run_phase(C_MAXY_W'($urandom_range(2034, 1971)), 120);
        run_phase(C_MAXY_W'($urandom_range(2034, 1971)), 120);
        run_phase(11'd2034, 120);

        repeat (20) @(posedge i_clk);
        $display("Sent %0d dates over %0d max_year settings; %0d results checked",
                 dates_sent, settings_used, sb.dates_checked);
        $display("%0d dates in calendar range, %0d mismatches",
                 sb.in_range_dates, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
